[src/modulation_waveform_source_top_macros.svh]
// assertion macros for the modulation waveform source
// used by the modules that carry concurrent checks
`ifndef MODULATION_WAVEFORM_SOURCE_TOP_MACROS_SVH
`define MODULATION_WAVEFORM_SOURCE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MWS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MWS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MWS_ASSERT(lbl, clk, rst, prop, msg)
`define MWS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

[src/mws_pkg.sv]
// shared types, constants and the sine table function of the waveform source
// no dependencies
package mws_pkg;

  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 17;
  localparam int INV_W      = 48;
  localparam int PHASE_W    = 16;
  localparam int MODE_W     = 3;
  localparam int DIV_W      = TIME_W + 1;
  localparam int PROD_W     = 50;
  localparam int ROM_W      = 16;
  localparam int CFG_DATA_W = INV_W;
  localparam int CFG_IDX_W  = 3;

  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(65536);
  localparam logic [LEVEL_W-1:0] LEVEL_HALF = LEVEL_W'(32768);
  localparam logic [TIME_W-1:0]  TIME_HALF  = TIME_W'(32768);

  localparam logic [TIME_W-1:0] MAIN_LEN_RST = TIME_W'(65536);
  localparam logic [INV_W-1:0]  INV_RST      = INV_W'(64'h1_0000_0000);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [7:0]  TAYLOR_DIV [6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

  typedef enum logic [MODE_W-1:0] {
    MODE_SINE      = 3'd0,
    MODE_SQUARE    = 3'd1,
    MODE_TRIANGLE  = 3'd2,
    MODE_RAMP      = 3'd3,
    MODE_FADE_OUT  = 3'd4,
    MODE_FADE_IN   = 3'd5,
    MODE_HOLD_FADE = 3'd6
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_MAIN_LEN   = 3'd1,
    REG_MAIN_INV   = 3'd2,
    REG_PHASE      = 3'd3,
    REG_SECOND_LEN = 3'd4,
    REG_SECOND_INV = 3'd5,
    REG_STOP       = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    mode_t               mode;
    logic [TIME_W-1:0]   main_len;
    logic [INV_W-1:0]    main_inv;
    logic [PHASE_W-1:0]  phase;
    logic [TIME_W-1:0]   second_len;
    logic [INV_W-1:0]    second_inv;
    logic                stop;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] tm;
    logic              sq_high;
  } ctx_t;

  // quarter sine entry in Q1.15, taylor series in Q30
  function automatic logic [ROM_W-1:0] rom_entry(input logic [63:0] idx, input int bits);
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic [63:0]        q;
    logic signed [63:0] sum;
    logic [ROM_W-1:0]   rv;
    int                 k;
    a    = (HALF_PI_Q30 * idx) >> bits;
    a2   = (a * a) >> 30;
    term = a;
    sum  = signed'(a);
    for (k = 1; k <= 6; k++) begin
      term = ((term * a2) >> 30) / 64'(TAYLOR_DIV[k-1]);
      if ((k & 1) != 0) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum <= 0) begin
      rv = '0;
    end else begin
      q  = ((unsigned'(sum) * 64'd32768) + 64'd536870912) >> 30;
      rv = (q > 64'd32768) ? ROM_W'(32768) : q[ROM_W-1:0];
    end
    return rv;
  endfunction

endpackage

[src/mws_if.sv]
// stream interfaces of the waveform source: time values in, levels out
// depends on mws_pkg
interface mws_time_if import mws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_now;

  modport source (output valid, output time_now, input ready);
  modport sink (input valid, input time_now, output ready);
endinterface

interface mws_level_if import mws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic               active;

  modport source (output valid, output level, output active, input ready);
  modport sink (input valid, input level, input active, output ready);
endinterface

[src/mws_rem_pipe.sv]
// pipelined restoring remainder, one dividend bit per stage
// depends on mws_pkg and the assertion macros
`include "modulation_waveform_source_top_macros.svh"

module mws_rem_pipe import mws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [TIME_W-1:0] divisor,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  in_u,
  input  ctx_t              in_ctx,
  output logic              out_valid,
  output logic [TIME_W-1:0] out_rem,
  output ctx_t              out_ctx
);

  logic              st_valid [DIV_W+1];
  logic [TIME_W-1:0] st_rem   [DIV_W+1];
  logic [DIV_W-1:0]  st_u     [DIV_W+1];
  ctx_t              st_ctx   [DIV_W+1];

  assign st_valid[0] = in_valid;
  assign st_rem[0]   = '0;
  assign st_u[0]     = in_u;
  assign st_ctx[0]   = in_ctx;

  for (genvar g = 0; g < DIV_W; g++) begin : g_step
    logic [TIME_W:0]   trial;
    logic [TIME_W-1:0] rem_next;

    always_comb begin
      trial = {st_rem[g], st_u[g][DIV_W-1-g]};
      if (trial >= {1'b0, divisor}) rem_next = TIME_W'(trial - {1'b0, divisor});
      else rem_next = trial[TIME_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) st_valid[g+1] <= 1'b0;
      else if (en) st_valid[g+1] <= st_valid[g];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[g+1] <= rem_next;
        st_u[g+1]   <= st_u[g];
        st_ctx[g+1] <= st_ctx[g];
      end
    end
  end

  assign out_valid = st_valid[DIV_W];
  assign out_rem   = st_rem[DIV_W];
  assign out_ctx   = st_ctx[DIV_W];

  `MWS_ASSERT(a_rem_below_divisor, clk, rst, (out_valid && divisor != '0) |-> (out_rem < divisor), "remainder not below divisor")

endmodule

[src/mws_mul_pipe.sv]
// two stage reciprocal multiply: split partial products, then aligned sum
// depends on mws_pkg
module mws_mul_pipe import mws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              half_shift,
  input  logic              in_valid,
  input  logic [TIME_W-1:0] in_t,
  input  logic [INV_W-1:0]  in_inv,
  input  ctx_t              in_ctx,
  output logic              out_valid,
  output logic [PROD_W-1:0] out_v,
  output ctx_t              out_ctx
);

  logic                    p_valid;
  logic [TIME_W+15:0]      p_hi;
  logic [2*TIME_W-1:0]     p_lo;
  ctx_t                    p_ctx;
  logic [TIME_W+16:0]      hi_part;
  logic [TIME_W:0]         lo_part;
  logic [PROD_W-1:0]       v_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi    <= in_t * in_inv[INV_W-1:TIME_W];
      p_lo    <= in_t * in_inv[TIME_W-1:0];
      p_ctx   <= in_ctx;
      out_v   <= v_next;
      out_ctx <= p_ctx;
    end
  end

  always_comb begin
    if (half_shift) begin
      hi_part = {p_hi, 1'b0};
      lo_part = p_lo[2*TIME_W-1:TIME_W-1];
    end else begin
      hi_part = {1'b0, p_hi};
      lo_part = {1'b0, p_lo[2*TIME_W-1:TIME_W]};
    end
    v_next = PROD_W'(hi_part) + PROD_W'(lo_part);
  end

endmodule

[src/mws_shape.sv]
// waveform shaping: quarter-wave sine table, fades, hold, output level
// depends on mws_pkg
module mws_shape import mws_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  cfg_t               cfg,
  input  logic [TIME_W:0]    hold_end,
  input  logic               in_valid,
  input  logic [PROD_W-1:0]  in_v,
  input  ctx_t               in_ctx,
  output logic               out_valid,
  output logic [LEVEL_W-1:0] out_level,
  output logic               out_active
);

  localparam int ROM_LAST = 1 << SINE_TABLE_BITS;

  typedef logic [ROM_W-1:0] rom_t [0:ROM_LAST];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= ROM_LAST; i++) r[i] = rom_entry(64'(i), SINE_TABLE_BITS);
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  localparam logic [PROD_W-1:0] V_ONE = PROD_W'(LEVEL_ONE);
  localparam logic [PROD_W-1:0] V_TWO = PROD_W'(2 * 65536);

  logic [PHASE_W-1:0]         x;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS:0]   addr;
  logic [LEVEL_W-1:0]         clip;
  logic [LEVEL_W-1:0]         lvl_next;
  logic                       act_next;

  logic               a_valid;
  logic [ROM_W-1:0]   a_rom;
  logic               a_neg;
  logic               a_sine;
  logic [LEVEL_W-1:0] a_level;
  logic               a_active;

  always_comb begin
    x    = in_v[PHASE_W-1:0] + cfg.phase;
    idx  = x[13:14-SINE_TABLE_BITS];
    if (x[14]) addr = {1'b1, {SINE_TABLE_BITS{1'b0}}} - {1'b0, idx};
    else addr = {1'b0, idx};
    clip = (in_v > V_ONE) ? LEVEL_ONE : in_v[LEVEL_W-1:0];
  end

  always_comb begin
    lvl_next = '0;
    act_next = 1'b1;
    unique case (cfg.mode)
      MODE_SINE: lvl_next = '0;
      MODE_SQUARE: lvl_next = in_ctx.sq_high ? LEVEL_ONE : '0;
      MODE_TRIANGLE: begin
        if (in_v > V_ONE) begin
          lvl_next = (in_v >= V_TWO) ? '0 : LEVEL_W'(V_TWO - in_v);
        end else begin
          lvl_next = in_v[LEVEL_W-1:0];
        end
      end
      MODE_RAMP: lvl_next = clip;
      MODE_FADE_OUT, MODE_FADE_IN: begin
        if (cfg.main_len < in_ctx.tm) begin
          lvl_next = (cfg.mode == MODE_FADE_IN) ? LEVEL_ONE : '0;
          act_next = !cfg.stop;
        end else begin
          lvl_next = (cfg.mode == MODE_FADE_IN) ? clip : LEVEL_ONE - clip;
        end
      end
      MODE_HOLD_FADE: begin
        if (in_ctx.tm <= cfg.main_len) begin
          lvl_next = LEVEL_ONE;
        end else if (hold_end <= {1'b0, in_ctx.tm}) begin
          lvl_next = '0;
          act_next = !cfg.stop;
        end else begin
          lvl_next = (in_v >= V_ONE) ? '0 : LEVEL_ONE - in_v[LEVEL_W-1:0];
        end
      end
      default: lvl_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_rom    <= SINE_ROM[addr];
      a_neg    <= x[15];
      a_sine   <= (cfg.mode == MODE_SINE);
      a_level  <= lvl_next;
      a_active <= act_next;
      if (a_sine) begin
        out_level <= a_neg ? LEVEL_HALF - {1'b0, a_rom} : LEVEL_HALF + {1'b0, a_rom};
      end else begin
        out_level <= a_level;
      end
      out_active <= a_active;
    end
  end

endmodule

[src/modulation_waveform_source_top.sv]
// modulation waveform source: lfo shapes and envelopes from a time value
// depends on mws_pkg, mws_if, mws_rem_pipe, mws_mul_pipe, mws_shape, macros
//
// time_stream carries one unsigned Q16.16 time value per transfer; level_stream
// returns one Q1.16 level and an active flag per transfer, in input order.
// Registers are written through cfg_write / cfg_index / cfg_data; the user must
// write them only while no item is in flight, the block does not enforce this;
// index 0 mode, 1 main length, 2 its reciprocal, 3 phase, 4 second length, 5 its
// reciprocal, 6 stop at end. An input transfer reaches level_stream through one
// input stage, 33 stages of the bit-serial remainder pipe (one stage per dividend
// bit), one operand select stage, two multiply stages, two shaping stages and the
// output register. A time value is taken every cycle unless the spare is full.
// Reset loads the register defaults and empties the pipeline; input is taken
// in the first cycle after reset.
// When the receiver stalls, the output register holds and one more result
// lands in a spare register; time_stream.ready then drops and the whole
// pipeline freezes until the spare drains.
`include "modulation_waveform_source_top_macros.svh"

module modulation_waveform_source_top import mws_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mws_time_if.sink              time_stream,
  mws_level_if.source           level_stream
);

  cfg_t              cfg;
  cfg_t              cfg_next;
  logic [TIME_W-1:0] off;
  logic [TIME_W:0]   hold_end;
  logic              advance;

  logic              s1_valid;
  logic [TIME_W-1:0] s1_tm;
  logic [DIV_W-1:0]  s1_u;
  ctx_t              s1_ctx;

  logic              r_valid;
  logic [TIME_W-1:0] r_rem;
  ctx_t              r_ctx;
  logic [TIME_W-1:0] rem_eff;

  logic              sel_valid;
  logic [TIME_W-1:0] sel_t;
  logic [INV_W-1:0]  sel_inv;
  ctx_t              sel_ctx;
  logic [TIME_W-1:0] t_next;

  logic              m_valid;
  logic [PROD_W-1:0] m_v;
  ctx_t              m_ctx;

  logic               sh_valid;
  logic [LEVEL_W-1:0] sh_level;
  logic               sh_active;
  logic               fire;

  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;
  logic               out_active;
  logic               spare_valid;
  logic [LEVEL_W-1:0] spare_level;
  logic               spare_active;

  // configuration registers
  always_comb begin
    cfg_next = cfg;
    if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:       cfg_next.mode       = mode_t'(cfg_data[MODE_W-1:0]);
        REG_MAIN_LEN:   cfg_next.main_len   = cfg_data[TIME_W-1:0];
        REG_MAIN_INV:   cfg_next.main_inv   = cfg_data[INV_W-1:0];
        REG_PHASE:      cfg_next.phase      = cfg_data[PHASE_W-1:0];
        REG_SECOND_LEN: cfg_next.second_len = cfg_data[TIME_W-1:0];
        REG_SECOND_INV: cfg_next.second_inv = cfg_data[INV_W-1:0];
        REG_STOP:       cfg_next.stop       = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_SINE;
      cfg.main_len   <= MAIN_LEN_RST;
      cfg.main_inv   <= INV_RST;
      cfg.phase      <= '0;
      cfg.second_len <= MAIN_LEN_RST;
      cfg.second_inv <= INV_RST;
      cfg.stop       <= 1'b0;
    end else begin
      cfg <= cfg_next;
    end
  end

  // values that follow from the registers alone, loaded with the write itself
  always_ff @(posedge clk) begin
    if (rst) begin
      off      <= '0;
      hold_end <= {1'b0, MAIN_LEN_RST} + {1'b0, MAIN_LEN_RST};
    end else begin
      off      <= TIME_W'(({32'b0, cfg_next.phase} * {16'b0, cfg_next.main_len}) >> PHASE_W);
      hold_end <= {1'b0, cfg_next.main_len} + {1'b0, cfg_next.second_len};
    end
  end

  assign advance           = !spare_valid;
  assign time_stream.ready = advance;

  // input stage: dividend for the wrap
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (advance) s1_valid <= time_stream.valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tm <= time_stream.time_now;
      if (cfg.mode == MODE_SQUARE) s1_u <= {1'b0, time_stream.time_now};
      else s1_u <= {1'b0, time_stream.time_now} + {1'b0, off};
    end
  end

  assign s1_ctx = '{tm: s1_tm, sq_high: 1'b0};

  mws_rem_pipe u_rem (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .divisor   (cfg.main_len),
    .in_valid  (s1_valid),
    .in_u      (s1_u),
    .in_ctx    (s1_ctx),
    .out_valid (r_valid),
    .out_rem   (r_rem),
    .out_ctx   (r_ctx)
  );

  // operand select for the reciprocal multiply
  always_comb begin
    rem_eff = (cfg.main_len == '0) ? '0 : r_rem;
    unique case (cfg.mode)
      MODE_TRIANGLE, MODE_RAMP: t_next = rem_eff;
      MODE_HOLD_FADE:           t_next = r_ctx.tm - cfg.main_len;
      default:                  t_next = r_ctx.tm;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) sel_valid <= 1'b0;
    else if (advance) sel_valid <= r_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sel_t          <= t_next;
      sel_inv        <= (cfg.mode == MODE_HOLD_FADE) ? cfg.second_inv : cfg.main_inv;
      sel_ctx.tm     <= r_ctx.tm;
      sel_ctx.sq_high <= (rem_eff < TIME_HALF);
    end
  end

  mws_mul_pipe u_mul (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .half_shift (cfg.mode == MODE_TRIANGLE),
    .in_valid   (sel_valid),
    .in_t       (sel_t),
    .in_inv     (sel_inv),
    .in_ctx     (sel_ctx),
    .out_valid  (m_valid),
    .out_v      (m_v),
    .out_ctx    (m_ctx)
  );

  mws_shape #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_shape (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .cfg        (cfg),
    .hold_end   (hold_end),
    .in_valid   (m_valid),
    .in_v       (m_v),
    .in_ctx     (m_ctx),
    .out_valid  (sh_valid),
    .out_level  (sh_level),
    .out_active (sh_active)
  );

  // output register with spare entry
  assign fire = sh_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!out_valid || level_stream.ready) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        out_level   <= spare_level;
        out_active  <= spare_active;
        spare_valid <= 1'b0;
      end else begin
        out_valid  <= fire;
        out_level  <= sh_level;
        out_active <= sh_active;
      end
    end else if (fire) begin
      spare_valid  <= 1'b1;
      spare_level  <= sh_level;
      spare_active <= sh_active;
    end
  end

  assign level_stream.valid  = out_valid;
  assign level_stream.level  = out_level;
  assign level_stream.active = out_active;

  `MWS_ASSERT(a_level_range, clk, rst, out_valid |-> (out_level <= LEVEL_ONE), "level above one")
  `MWS_ASSERT(a_spare_needs_out, clk, rst, spare_valid |-> out_valid, "spare full while output empty")
  `MWS_ASSERT(a_spare_fill, clk, rst, $rose(spare_valid) |-> $past(out_valid && !level_stream.ready), "spare filled without stall")
  `MWS_ASSERT_NEXT(a_stall_holds, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_tm), "input stage lost during stall")

endmodule

[tb/sv/modulation_waveform_source_top_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for modulation_waveform_source_top: directed and random
// time values under many register settings, each level predicted and compared in order
// depends on mws_pkg, mws_if and the rtl of the waveform source
module modulation_waveform_source_top_test;
  import mws_pkg::*;

  localparam int SINE_BITS = SINE_TABLE_BITS_DEF;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [63:0] UNIT = 64'd65536;
  localparam int LATENCY = 39;
  localparam int RANDOM_ITEMS = 1050;

  typedef struct {
    logic [TIME_W-1:0]  tm;
    logic [LEVEL_W-1:0] level;
    logic               active;
  } level_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  cfg_reg_t cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mws_time_if  time_ch ();
  mws_level_if level_ch ();

  modulation_waveform_source_top #(
    .SINE_TABLE_BITS(SINE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .time_stream(time_ch),
    .level_stream(level_ch)
  );

  // shadow copy of the register file
  logic [MODE_W-1:0]  cfg_mode = MODE_SINE;
  logic [TIME_W-1:0]  cfg_main_len = MAIN_LEN_RST;
  logic [INV_W-1:0]   cfg_main_inv = INV_RST;
  logic [PHASE_W-1:0] cfg_phase = '0;
  logic [TIME_W-1:0]  cfg_second_len = MAIN_LEN_RST;
  logic [INV_W-1:0]   cfg_second_inv = INV_RST;
  logic               cfg_stop = 1'b0;

  logic [TIME_W-1:0] time_queue [$];
  level_entry_t      expected_levels [$];
  logic              took_input = 1'b0;
  logic              quiet = 1'b0;
  int                errors = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // sin(pi/2 * i / 2^SINE_BITS) in Q1.15 from a taylor series in Q30
  function automatic logic [15:0] quarter_sine(input logic [63:0] i);
    logic [63:0]        ang;
    logic [63:0]        ang_sq;
    logic [63:0]        term;
    logic [63:0]        q;
    logic signed [63:0] acc;
    int                 k;
    ang    = (QUARTER_TURN_Q30 * i) >> SINE_BITS;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = signed'(ang);
    for (k = 1; k <= 6; k++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - signed'(term);
      else acc = acc + signed'(term);
    end
    if (acc <= 0) return 16'd0;
    q = (unsigned'(acc) * 64'd32768 + 64'd536870912) >> 30;
    return (q > 64'd32768) ? 16'd32768 : q[15:0];
  endfunction

  // (t * inv) >> s, split so the products stay within 64 bits
  function automatic logic [63:0] scale_by_inverse(input logic [63:0] t,
                                                   input logic [INV_W-1:0] inv, input int s);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = 64'(inv[47:32]);
    lo = 64'(inv[31:0]);
    return ((t * hi) << (32 - s)) + ((t * lo) >> s);
  endfunction

  function automatic logic [63:0] wrap_to_period(input logic [63:0] u);
    return (cfg_main_len == 0) ? 64'd0 : u % 64'(cfg_main_len);
  endfunction

  function automatic void predict_level(input logic [TIME_W-1:0] tm,
                                        output logic [LEVEL_W-1:0] lvl, output logic act);
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] off;
    logic [63:0] idx;
    logic [63:0] s;
    logic [15:0] x;
    t   = 64'(tm);
    off = (64'(cfg_phase) * 64'(cfg_main_len)) >> 16;
    lvl = '0;
    act = 1'b1;
    case (cfg_mode)
      MODE_SINE: begin
        x   = 16'(scale_by_inverse(t, cfg_main_inv, 32) + 64'(cfg_phase));
        idx = 64'(x[13:0]) >> (14 - SINE_BITS);
        s   = x[14] ? 64'(quarter_sine((64'd1 << SINE_BITS) - idx)) : 64'(quarter_sine(idx));
        lvl = x[15] ? LEVEL_W'(64'd32768 - s) : LEVEL_W'(64'd32768 + s);
      end
      MODE_SQUARE: lvl = (wrap_to_period(t) < 64'd32768) ? LEVEL_ONE : '0;
      MODE_TRIANGLE: begin
        v = scale_by_inverse(wrap_to_period(t + off), cfg_main_inv, 31);
        if (v > UNIT) v = (v >= 2 * UNIT) ? 64'd0 : 2 * UNIT - v;
        lvl = LEVEL_W'(v);
      end
      MODE_RAMP: begin
        v   = scale_by_inverse(wrap_to_period(t + off), cfg_main_inv, 32);
        lvl = (v > UNIT) ? LEVEL_ONE : LEVEL_W'(v);
      end
      MODE_FADE_OUT, MODE_FADE_IN: begin
        if (64'(cfg_main_len) < t) begin
          lvl = (cfg_mode == MODE_FADE_IN) ? LEVEL_ONE : '0;
          act = !cfg_stop;
        end else begin
          v = scale_by_inverse(t, cfg_main_inv, 32);
          if (v > UNIT) v = UNIT;
          lvl = (cfg_mode == MODE_FADE_IN) ? LEVEL_W'(v) : LEVEL_W'(UNIT - v);
        end
      end
      MODE_HOLD_FADE: begin
        if (t <= 64'(cfg_main_len)) begin
          lvl = LEVEL_ONE;
        end else if (64'(cfg_main_len) + 64'(cfg_second_len) <= t) begin
          lvl = '0;
          act = !cfg_stop;
        end else begin
          v   = scale_by_inverse(t - 64'(cfg_main_len), cfg_second_inv, 32);
          lvl = (v >= UNIT) ? '0 : LEVEL_W'(UNIT - v);
        end
      end
      default: lvl = '0;
    endcase
  endfunction

  // monitor: records input transfers with their predicted level and checks results
  always @(posedge clk) begin
    level_entry_t want;
    took_input = 1'b0;
    if (!rst) begin
      if (time_ch.valid && time_ch.ready) begin
        took_input = 1'b1;
        want.tm = time_ch.time_now;
        predict_level(time_ch.time_now, want.level, want.active);
        expected_levels.push_back(want);
      end
      if (level_ch.valid && level_ch.ready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: level %0d active %0b",
                                    level_ch.level, level_ch.active));
        end else begin
          want = expected_levels.pop_front();
          if (level_ch.level !== want.level)
            report_mismatch($sformatf("time %h mode %0d: level %0d, wanted %0d",
                                      want.tm, cfg_mode, level_ch.level, want.level));
          if (level_ch.active !== want.active)
            report_mismatch($sformatf("time %h mode %0d: active %0b, wanted %0b",
                                      want.tm, cfg_mode, level_ch.active, want.active));
        end
      end
    end
  end

  // driver: time values from the queue, random gaps on both sides
  always @(negedge clk) begin
    if (rst) begin
      time_ch.valid    <= 1'b0;
      time_ch.time_now <= '0;
    end else if (!time_ch.valid || took_input) begin
      if (time_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
        time_ch.valid    <= 1'b1;
        time_ch.time_now <= time_queue.pop_front();
      end else begin
        time_ch.valid    <= 1'b0;
        time_ch.time_now <= $urandom;
      end
    end
    level_ch.ready <= quiet || ($urandom_range(0, 99) >= 12);
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MODE:       cfg_mode       = data[MODE_W-1:0];
      REG_MAIN_LEN:   cfg_main_len   = data[TIME_W-1:0];
      REG_MAIN_INV:   cfg_main_inv   = data[INV_W-1:0];
      REG_PHASE:      cfg_phase      = data[PHASE_W-1:0];
      REG_SECOND_LEN: cfg_second_len = data[TIME_W-1:0];
      REG_SECOND_INV: cfg_second_inv = data[INV_W-1:0];
      default:        cfg_stop       = data[0];
    endcase
  endtask

  task automatic set_all(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] len,
                         input logic [INV_W-1:0] inv, input logic [PHASE_W-1:0] ph,
                         input logic [TIME_W-1:0] flen, input logic [INV_W-1:0] finv,
                         input logic stp);
    write_reg(REG_MODE, CFG_DATA_W'(m));
    write_reg(REG_MAIN_LEN, CFG_DATA_W'(len));
    write_reg(REG_MAIN_INV, CFG_DATA_W'(inv));
    write_reg(REG_PHASE, CFG_DATA_W'(ph));
    write_reg(REG_SECOND_LEN, CFG_DATA_W'(flen));
    write_reg(REG_SECOND_INV, CFG_DATA_W'(finv));
    write_reg(REG_STOP, CFG_DATA_W'(stp));
  endtask

  task automatic wait_drained();
    while (time_queue.size() != 0 || time_ch.valid || expected_levels.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [INV_W-1:0] exact_inverse(input logic [TIME_W-1:0] len);
    logic [63:0] q;
    if (len == 0) return '1;
    q = (64'd1 << 48) / 64'(len);
    return (q > 64'hFFFF_FFFF_FFFF) ? '1 : q[INV_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return 32'd1;
    if (r < 15) return '1;
    if (r < 60) return $urandom_range(1, 32'h0008_0000);
    if (r < 85) return $urandom_range(1, 32'h0100_0000);
    return $urandom;
  endfunction

  function automatic logic [INV_W-1:0] pick_inverse(input logic [TIME_W-1:0] len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return {16'($urandom), 32'($urandom)};
    if (r < 20) return '1;
    return exact_inverse(len);
  endfunction

  // time values spread over the span of the current shape and around its corners
  function automatic logic [TIME_W-1:0] pick_time();
    logic [63:0] span;
    logic [63:0] pt;
    int          r;
    r = $urandom_range(0, 99);
    if (cfg_mode == MODE_HOLD_FADE) begin
      span = 64'(cfg_main_len) + 64'(cfg_second_len) + 64;
      pt   = r[0] ? 64'(cfg_main_len) : 64'(cfg_main_len) + 64'(cfg_second_len);
    end else if (cfg_mode == MODE_FADE_OUT || cfg_mode == MODE_FADE_IN) begin
      span = 64'(cfg_main_len) + 64;
      pt   = 64'(cfg_main_len);
    end else begin
      span = 3 * 64'(cfg_main_len) + 64;
      pt   = (cfg_mode == MODE_SQUARE && r[0]) ? 64'd32768 : 64'(cfg_main_len);
    end
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    if (r < 30) return $urandom;
    if (r < 75) return $urandom_range(0, span[31:0]);
    pt = pt + 64'($urandom_range(0, 4));
    pt = (pt < 2) ? 64'd0 : pt - 2;
    return (pt > 64'hFFFF_FFFF) ? '1 : pt[31:0];
  endfunction

  task automatic random_setup();
    logic [MODE_W-1:0] m;
    logic [TIME_W-1:0] len;
    logic [TIME_W-1:0] flen;
    m    = ($urandom_range(0, 99) < 5) ? 3'd7 : 3'($urandom_range(0, 6));
    len  = pick_length();
    flen = pick_length();
    set_all(m, len, pick_inverse(len), 16'($urandom), flen, pick_inverse(flen),
            1'($urandom_range(0, 1)));
  endtask

  initial begin
    int total;
    int n;
    int ph;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults: sine over one unit period, the four quadrant starts
    time_queue = '{32'h0, 32'h4000, 32'h8000, 32'hC000, 32'hFFFF_FFFF};
    wait_drained();
    // square with zero length
    set_all(MODE_SQUARE, 32'h0, '1, 16'h0, 32'h1, '1, 1'b1);
    time_queue = '{32'h0, 32'd40000};
    wait_drained();
    set_all(MODE_TRIANGLE, 32'h2_0000, exact_inverse(32'h2_0000), 16'h8000,
            32'h1_0000, INV_RST, 1'b0);
    time_queue = '{32'h0, 32'h1_0000, 32'hFFFF_FFFF};
    wait_drained();
    // ramp with the largest length, phase and a wrong reciprocal
    set_all(MODE_RAMP, 32'hFFFF_FFFF, '1, 16'hFFFF, 32'h1_0000, INV_RST, 1'b0);
    time_queue = '{32'h0, 32'hFFFF_FFFF};
    wait_drained();
    set_all(MODE_FADE_OUT, 32'h3_0000, exact_inverse(32'h3_0000), 16'h0,
            32'h1_0000, INV_RST, 1'b1);
    time_queue = '{32'h3_0000, 32'h3_0001};
    wait_drained();
    set_all(MODE_FADE_IN, 32'h3_0000, exact_inverse(32'h3_0000), 16'h0,
            32'h1_0000, INV_RST, 1'b0);
    time_queue = '{32'h3_0001, 32'h1_8000};
    wait_drained();
    set_all(MODE_HOLD_FADE, 32'h1_0000, INV_RST, 16'h0, 32'h2_0000,
            exact_inverse(32'h2_0000), 1'b1);
    time_queue = '{32'h1_0000, 32'h2_0000, 32'h3_0000, 32'hFFFF_FFFF};
    wait_drained();
    // hold plus fade beyond 32 bits
    set_all(MODE_HOLD_FADE, 32'h8000_0000, INV_RST, 16'h0, 32'h9000_0000,
            exact_inverse(32'h9000_0000), 1'b1);
    time_queue = '{32'hFFFF_FFFF};
    wait_drained();
    // unused mode
    set_all(3'd7, 32'h1_0000, INV_RST, 16'h1234, 32'h1_0000, INV_RST, 1'b1);
    time_queue = '{32'h1234};
    wait_drained();

    total = 0;
    ph    = 0;
    while (total < RANDOM_ITEMS) begin
      random_setup();
      quiet = (ph == 3);
      n     = quiet ? 200 : $urandom_range(20, 70);
      repeat (n) time_queue.push_back(pick_time());
      total += n;
      ph++;
      wait_drained();
    end
    quiet = 1'b0;

    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_levels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
